/* sv/mlti_pkg.sv */
// ----------------------------------------------------------------------------
// mlti_pkg: shared types and codes of the multiline terminal interface
// Item and result beats, per-line status and update records, register and
// error codes.
// ----------------------------------------------------------------------------
package mlti_pkg;

    // Request kinds carried in an input beat
    typedef enum logic [1:0] {
        REQ_IOT    = 2'd0,
        REQ_RX     = 2'd1,
        REQ_TXDONE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NODEV   = 2'd1;
    localparam logic [1:0] ERR_PULSE   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_LINES = 1'b0;
    localparam logic CFG_BASE  = 1'b1;

    localparam int CFG_W = 6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] iot_word;
        logic [11:0] acc_in;
        logic [3:0]  event_line;
        logic [7:0]  rx_char;
        logic        rx_break;
    } item_t;

    typedef struct packed {
        logic [11:0] acc_out;
        logic        skip;
        logic [1:0]  error_code;
        logic        tx_start;
        logic        tx_valid;
        logic [3:0]  tx_line;
        logic [7:0]  tx_char;
        logic        rx_accepted;
        logic        irq_input;
        logic        irq_output;
    } result_t;

    // Status of the one line an item touches
    typedef struct packed {
        logic       rx_done;
        logic       tx_done;
        logic       irq_en;
        logic [7:0] rx_buf;
        logic [7:0] tx_buf;
    } line_stat_t;

    // State changes an item makes on its line
    typedef struct packed {
        logic [3:0] line;
        logic       rx_done_set;
        logic       rx_done_clr;
        logic       tx_done_set;
        logic       tx_done_clr;
        logic       irq_en_set;
        logic       irq_en_clr;
        logic       rx_buf_we;
        logic       tx_buf_we;
        logic [7:0] wdata;
    } line_upd_t;

    // Line reset request from a line count write
    typedef struct packed {
        logic       en;
        logic [4:0] first;
    } line_rst_t;

endpackage

/* sv/multiline_terminal_iot_interface_unit.sv */
// ----------------------------------------------------------------------------
// multiline_terminal_iot_interface_unit: multiline terminal I/O interface
// An accepted input beat is held in the input register, then one pass of
// decode and line update forms its result beat in the result register.
// Throughput: one beat per cycle while out_stall is low, set by the line state update.
// Reset: flags clear, interrupt enables set, buffers read zero, 4 lines at
// base device 32; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module multiline_terminal_iot_interface_unit
#(
    parameter int MAX_LINES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [11:0] iot_word,
    input  logic [11:0] acc_in,
    input  logic [3:0]  event_line,
    input  logic [7:0]  rx_char,
    input  logic        rx_break,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] acc_out,
    output logic        skip,
    output logic [1:0]  error_code,
    output logic        tx_start,
    output logic        tx_valid,
    output logic [3:0]  tx_line,
    output logic [7:0]  tx_char,
    output logic        rx_accepted,
    output logic        irq_input,
    output logic        irq_output,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [mlti_pkg::CFG_W-1:0] cfg_data
);
    import mlti_pkg::*;

    localparam logic [4:0] MAX_N     = 5'(MAX_LINES);
    localparam logic [4:0] LINES_RST = (MAX_LINES < 4) ? 5'(MAX_LINES) : 5'd4;

    logic [4:0]  lines_reg;
    logic [5:0]  base_reg;
    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    logic        advance;
    logic        take;
    logic [4:0]  n_raw;
    logic [4:0]  n_sat;
    line_rst_t   lrst;
    logic [3:0]  rd_line;
    line_stat_t  stat;
    result_t     res;
    line_upd_t   upd;
    logic        irq_in_next;
    logic        irq_out_next;
    result_t     res_full;

    // Handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    // Line count write: saturate, ignore zero, reset lines above the smaller count
    always_comb
    begin
        n_raw      = cfg_data[4:0];
        n_sat      = (n_raw > MAX_N) ? MAX_N : n_raw;
        lrst.en    = cfg_we && (cfg_index == CFG_LINES) && (n_raw != 5'd0);
        lrst.first = (n_sat < lines_reg) ? n_sat : lines_reg;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg <= LINES_RST;
            base_reg  <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINES:
                begin
                    if (n_raw != 5'd0)
                    begin
                        lines_reg <= n_sat;
                    end
                end
                CFG_BASE: base_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    mlti_exec u_exec
    (
        .item    (s1_item_reg),
        .lines   (lines_reg),
        .base    (base_reg),
        .rd_line (rd_line),
        .stat    (stat),
        .res     (res),
        .upd     (upd)
    );

    mlti_lines #(.MAX_LINES(MAX_LINES)) u_lines
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_line    (rd_line),
        .stat       (stat),
        .upd_en     (s1_valid_reg && advance),
        .upd        (upd),
        .lrst       (lrst),
        .irq_input  (irq_in_next),
        .irq_output (irq_out_next)
    );

    // Merge the summary interrupts taken after the update
    always_comb
    begin
        res_full            = res;
        res_full.irq_input  = irq_in_next;
        res_full.irq_output = irq_out_next;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Capture input beat and result beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= '{req_type, iot_word, acc_in, event_line, rx_char, rx_break};
        end
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_full;
        end
    end

    assign out_valid   = out_valid_reg;
    assign acc_out     = res_reg.acc_out;
    assign skip        = res_reg.skip;
    assign error_code  = res_reg.error_code;
    assign tx_start    = res_reg.tx_start;
    assign tx_valid    = res_reg.tx_valid;
    assign tx_line     = res_reg.tx_line;
    assign tx_char     = res_reg.tx_char;
    assign rx_accepted = res_reg.rx_accepted;
    assign irq_input   = res_reg.irq_input;
    assign irq_output  = res_reg.irq_output;

endmodule

/* sv/mlti_exec.sv */
// ----------------------------------------------------------------------------
// mlti_exec: decode and execute one item
// Matches the device code to a line, runs the pulse or event and forms the
// result fields and the state changes for that line.
// ----------------------------------------------------------------------------
module mlti_exec
(
    input  mlti_pkg::item_t      item,
    input  logic [4:0]           lines,
    input  logic [5:0]           base,
    output logic [3:0]           rd_line,
    input  mlti_pkg::line_stat_t stat,
    output mlti_pkg::result_t    res,
    output mlti_pkg::line_upd_t  upd
);
    import mlti_pkg::*;

    // Pulse codes
    localparam logic [2:0] P_CLR_DONE  = 3'd0;
    localparam logic [2:0] P_SKIP      = 3'd1;
    localparam logic [2:0] P_CLR_ACC   = 3'd2;
    localparam logic [2:0] P_READ_OR   = 3'd4;
    localparam logic [2:0] P_ENABLE    = 3'd5;
    localparam logic [2:0] P_READ      = 3'd6;
    localparam logic [2:0] T_SET_DONE  = 3'd0;
    localparam logic [2:0] T_SKIP      = 3'd1;
    localparam logic [2:0] T_CLR_DONE  = 3'd2;
    localparam logic [2:0] T_LOAD      = 3'd4;
    localparam logic [2:0] T_SKIP_ANY  = 3'd5;
    localparam logic [2:0] T_CLR_LOAD  = 3'd6;

    logic [5:0] dev;
    logic [2:0] pulse;
    logic [5:0] off;
    logic       dev_bad;
    logic       ev_bad;
    logic [3:0] ln;

    // Match the device code against the active range
    always_comb
    begin
        dev     = item.iot_word[8:3];
        pulse   = item.iot_word[2:0];
        off     = dev - base;
        dev_bad = (dev < base) || (off >= {lines, 1'b0});
        ev_bad  = ({1'b0, item.event_line} >= lines);
        ln      = off[4:1];
        rd_line = (req_t'(item.req_type) == REQ_IOT) ? ln : item.event_line;
    end

    // Execute the pulse or event
    always_comb
    begin
        res             = '0;
        res.acc_out     = item.acc_in;
        res.error_code  = ERR_NONE;
        upd             = '0;
        upd.line        = rd_line;

        unique case (req_t'(item.req_type))
            REQ_IOT:
            begin
                if (dev_bad)
                begin
                    res.error_code = ERR_NODEV;
                end
                else if (off[0])
                begin
                    unique case (pulse) inside
                        T_SET_DONE: upd.tx_done_set = 1'b1;
                        T_SKIP:     res.skip = stat.tx_done;
                        T_CLR_DONE: upd.tx_done_clr = 1'b1;
                        T_SKIP_ANY: res.skip = (stat.rx_done | stat.tx_done) & stat.irq_en;
                        T_LOAD, T_CLR_LOAD:
                        begin
                            upd.tx_done_clr = (pulse == T_CLR_LOAD);
                            upd.tx_buf_we   = 1'b1;
                            upd.wdata       = item.acc_in[7:0];
                            res.tx_start    = 1'b1;
                            res.tx_line     = ln;
                            res.tx_char     = item.acc_in[7:0];
                        end
                        default:    res.error_code = ERR_PULSE;
                    endcase
                end
                else
                begin
                    unique case (pulse)
                        P_CLR_DONE: upd.rx_done_clr = 1'b1;
                        P_SKIP:     res.skip = stat.rx_done;
                        P_CLR_ACC:
                        begin
                            upd.rx_done_clr = 1'b1;
                            res.acc_out     = '0;
                        end
                        P_READ_OR:  res.acc_out = item.acc_in | {4'd0, stat.rx_buf};
                        P_ENABLE:
                        begin
                            upd.irq_en_set = item.acc_in[0];
                            upd.irq_en_clr = ~item.acc_in[0];
                        end
                        P_READ:
                        begin
                            upd.rx_done_clr = 1'b1;
                            res.acc_out     = {4'd0, stat.rx_buf};
                        end
                        default:    res.error_code = ERR_PULSE;
                    endcase
                end
            end
            REQ_RX:
            begin
                if (ev_bad)
                begin
                    res.error_code = ERR_NODEV;
                end
                else if (!stat.rx_done)
                begin
                    upd.rx_buf_we   = 1'b1;
                    upd.wdata       = item.rx_break ? 8'd0 : item.rx_char;
                    upd.rx_done_set = 1'b1;
                    res.rx_accepted = 1'b1;
                end
            end
            REQ_TXDONE:
            begin
                if (ev_bad)
                begin
                    res.error_code = ERR_NODEV;
                end
                else
                begin
                    res.tx_valid    = 1'b1;
                    res.tx_line     = item.event_line;
                    res.tx_char     = stat.tx_buf;
                    upd.tx_done_set = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* sv/mlti_lines.sv */
// ----------------------------------------------------------------------------
// mlti_lines: per-line flags and character buffers
// Holds done flags, interrupt enables and buffers; serves one line's status
// per cycle, applies item updates and line resets, forms the summary irqs.
// ----------------------------------------------------------------------------
module mlti_lines
#(
    parameter int MAX_LINES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           rd_line,
    output mlti_pkg::line_stat_t stat,
    input  logic                 upd_en,
    input  mlti_pkg::line_upd_t  upd,
    input  mlti_pkg::line_rst_t  lrst,
    output logic                 irq_input,
    output logic                 irq_output
);
    import mlti_pkg::*;

    localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [MAX_LINES-1:0] rx_done_reg, rx_done_next;
    logic [MAX_LINES-1:0] tx_done_reg, tx_done_next;
    logic [MAX_LINES-1:0] ien_reg, ien_next;
    logic [MAX_LINES-1:0] rxv_reg, rxv_next;
    logic [MAX_LINES-1:0] txv_reg, txv_next;
    logic [7:0]           rx_buf_reg [MAX_LINES];
    logic [7:0]           tx_buf_reg [MAX_LINES];
    logic [MAX_LINES-1:0] m;
    logic [MAX_LINES-1:0] rmask;
    logic [LW-1:0]        ri;
    logic [LW-1:0]        wi;

    // Read the addressed line; an unwritten buffer reads as zero
    always_comb
    begin
        ri           = rd_line[LW-1:0];
        stat.rx_done = rx_done_reg[ri];
        stat.tx_done = tx_done_reg[ri];
        stat.irq_en  = ien_reg[ri];
        stat.rx_buf  = rxv_reg[ri] ? rx_buf_reg[ri] : 8'd0;
        stat.tx_buf  = txv_reg[ri] ? tx_buf_reg[ri] : 8'd0;
    end

    // Next flag values: line reset or item update
    always_comb
    begin
        wi = upd.line[LW-1:0];
        m  = MAX_LINES'(1) << upd.line;
        for (int i = 0; i < MAX_LINES; i++)
        begin
            rmask[i] = (5'(i) >= lrst.first);
        end
        rx_done_next = rx_done_reg;
        tx_done_next = tx_done_reg;
        ien_next     = ien_reg;
        rxv_next     = rxv_reg;
        txv_next     = txv_reg;
        if (lrst.en)
        begin
            rx_done_next = rx_done_reg & ~rmask;
            tx_done_next = tx_done_reg & ~rmask;
            ien_next     = ien_reg | rmask;
            rxv_next     = rxv_reg & ~rmask;
            txv_next     = txv_reg & ~rmask;
        end
        else if (upd_en)
        begin
            rx_done_next = (rx_done_reg & ~(upd.rx_done_clr ? m : '0))
                         | (upd.rx_done_set ? m : '0);
            tx_done_next = (tx_done_reg & ~(upd.tx_done_clr ? m : '0))
                         | (upd.tx_done_set ? m : '0);
            ien_next     = (ien_reg & ~(upd.irq_en_clr ? m : '0))
                         | (upd.irq_en_set ? m : '0);
            rxv_next     = rxv_reg | (upd.rx_buf_we ? m : '0);
            txv_next     = txv_reg | (upd.tx_buf_we ? m : '0);
        end
        irq_input  = |(rx_done_next & ien_next);
        irq_output = |(tx_done_next & ien_next);
    end

    // Hold flags and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_done_reg <= '0;
            tx_done_reg <= '0;
            ien_reg     <= '1;
            rxv_reg     <= '0;
            txv_reg     <= '0;
        end
        else
        begin
            rx_done_reg <= rx_done_next;
            tx_done_reg <= tx_done_next;
            ien_reg     <= ien_next;
            rxv_reg     <= rxv_next;
            txv_reg     <= txv_next;
        end
    end

    // Write buffers
    always_ff @(posedge clk)
    begin
        if (upd_en && !lrst.en && upd.rx_buf_we)
        begin
            rx_buf_reg[wi] <= upd.wdata;
        end
        if (upd_en && !lrst.en && upd.tx_buf_we)
        begin
            tx_buf_reg[wi] <= upd.wdata;
        end
    end

endmodule
